>>> hdl/hws_pkg.sv
package hws_pkg;

  localparam int HOURS_PER_DAY = 24;
  localparam int HOUR_W        = 5;
  localparam int CNT_W         = 8;
  localparam int SLEEP_W       = 17;
  localparam int DIV_W         = 12;
  localparam int DIV_CNT_W     = $clog2(DIV_W);

  typedef logic [DIV_W-1:0]   div_word_t;
  typedef logic [HOUR_W-1:0]  hour_t;
  typedef logic [CNT_W-1:0]   count_t;
  typedef logic [SLEEP_W-1:0] sleep_t;

  localparam div_word_t SECS_PER_HOUR = DIV_W'(3600);
  localparam div_word_t LAST_SECOND   = DIV_W'(3599);

endpackage

>>> hdl/hws_div.sv
module hws_div (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  hws_pkg::div_word_t dividend,
  input  hws_pkg::div_word_t divisor,
  output logic              done,
  output hws_pkg::div_word_t quotient,
  output hws_pkg::div_word_t remainder
);
  import hws_pkg::*;

  logic                 run;
  logic [DIV_CNT_W-1:0] cnt;
  div_word_t            acc;
  div_word_t            quo;
  div_word_t            dvs;
  logic [DIV_W:0]       trial;
  logic [DIV_W:0]       diff;
  logic                 ge;
  div_word_t            acc_next;
  div_word_t            quo_next;

  // one restoring step per cycle
  always_comb begin
    trial    = {acc, quo[DIV_W-1]};
    ge       = trial >= {1'b0, dvs};
    diff     = trial - {1'b0, dvs};
    acc_next = ge ? diff[DIV_W-1:0] : trial[DIV_W-1:0];
    quo_next = {quo[DIV_W-2:0], ge};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        acc <= '0;
        quo <= dividend;
        dvs <= divisor;
        cnt <= '0;
        run <= 1'b1;
      end else if (run) begin
        acc <= acc_next;
        quo <= quo_next;
        if (cnt == DIV_CNT_W'(DIV_W - 1)) begin
          run  <= 1'b0;
          done <= 1'b1;
        end else begin
          cnt <= cnt + 1'b1;
        end
      end
    end
  end

  assign quotient  = quo;
  assign remainder = acc;

endmodule

>>> hdl/hourly_wakeup_scheduler_core.sv
// Hourly wake-up scheduler.
// A transaction is taken at a rising edge with start high and busy low.
// operation 0 writes refresh_count into the entry selected by hour (hours
// 24..31 are ignored); the write lands at that edge, gives no result and
// busy stays low, so a transaction may follow in the next cycle.
// operation 1 is a query: busy rises for the whole computation and the
// answer appears on sleep_seconds / no_refresh with done high for exactly
// one cycle, the same cycle busy falls. The entry of the query hour is read
// first; if it is nonzero, two passes of a shared 12-step restoring divider
// (period, then position modulo period) follow, and if the next period
// boundary falls inside the hour the answer is given. Otherwise a scan of up
// to 24 following hours, one table entry per cycle, finds the next scheduled
// hour. The next transaction can be taken at the edge that ends the
// done cycle. The receiver cannot stall; done is a single-cycle strobe,
// and sleep_seconds / no_refresh hold the result until the next query
// completes.
// Synchronous reset clears the whole table to zero, drops busy and done.
// With an all-zero table a query returns 0 with no_refresh set.
module hourly_wakeup_scheduler_core (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  output logic                busy,
  input  logic                operation,
  input  hws_pkg::hour_t      hour,
  input  logic [5:0]          minute,
  input  logic [5:0]          second,
  input  hws_pkg::count_t     refresh_count,
  output logic                done,
  output hws_pkg::sleep_t     sleep_seconds,
  output logic                no_refresh
);
  import hws_pkg::*;

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_LOOKUP = 3'd1;
  localparam logic [2:0] ST_PERIOD = 3'd2;
  localparam logic [2:0] ST_REM    = 3'd3;
  localparam logic [2:0] ST_SCAN   = 3'd4;

  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  logic [2:0] state;
  count_t     sched [HOURS_PER_DAY];
  hour_t      idx;
  hour_t      step;
  div_word_t  pos;
  div_word_t  period;
  sleep_t     sleep;

  count_t     entry;
  logic       accept;
  div_word_t  raw_pos;
  div_word_t  sat_pos;
  hour_t      query_hour;
  hour_t      idx_next;
  div_word_t  align;
  logic [DIV_W:0] align_end;
  sleep_t     tail;

  logic       div_start;
  logic       div_done;
  div_word_t  div_a;
  div_word_t  div_b;
  div_word_t  div_quot;
  div_word_t  div_rem;

  function automatic hour_t hour_inc(input hour_t h);
    hour_inc = (h == HOUR_W'(HOURS_PER_DAY - 1)) ? '0 : h + 1'b1;
  endfunction

  always_comb begin
    accept     = start && !busy;
    entry      = sched[idx];
    raw_pos    = (DIV_W'(minute) << 6) - (DIV_W'(minute) << 2) + DIV_W'(second);
    sat_pos    = (raw_pos > LAST_SECOND) ? LAST_SECOND : raw_pos;
    query_hour = (hour >= HOUR_W'(HOURS_PER_DAY)) ? hour - HOUR_W'(HOURS_PER_DAY) : hour;
    idx_next   = hour_inc(idx);
    align      = period - div_rem;
    align_end  = {1'b0, pos} + {1'b0, align};
    tail       = SLEEP_W'(SECS_PER_HOUR - pos);
    div_start  = ((state == ST_LOOKUP) && (entry != '0)) ||
                 ((state == ST_PERIOD) && div_done);
    div_a      = (state == ST_LOOKUP) ? SECS_PER_HOUR : pos;
    div_b      = (state == ST_LOOKUP) ? DIV_W'(entry) : div_quot;
  end

  hws_div u_div (
    .clk       (clk),
    .rst       (rst),
    .start     (div_start),
    .dividend  (div_a),
    .divisor   (div_b),
    .done      (div_done),
    .quotient  (div_quot),
    .remainder (div_rem)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < HOURS_PER_DAY; i++) begin
        sched[i] <= '0;
      end
    end else if (accept && (operation == OP_WRITE) && (hour < HOUR_W'(HOURS_PER_DAY))) begin
      sched[hour] <= refresh_count;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      busy       <= 1'b0;
      done       <= 1'b0;
      no_refresh <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        ST_IDLE: begin
          if (accept && (operation == OP_QUERY)) begin
            idx   <= query_hour;
            pos   <= sat_pos;
            busy  <= 1'b1;
            state <= ST_LOOKUP;
          end
        end
        ST_LOOKUP: begin
          if (entry != '0) begin
            state <= ST_PERIOD;
          end else begin
            sleep <= tail;
            step  <= '0;
            idx   <= idx_next;
            state <= ST_SCAN;
          end
        end
        ST_PERIOD: begin
          if (div_done) begin
            period <= div_quot;
            state  <= ST_REM;
          end
        end
        ST_REM: begin
          if (div_done) begin
            if (align_end < {1'b0, SECS_PER_HOUR}) begin
              sleep_seconds <= SLEEP_W'(align);
              no_refresh    <= 1'b0;
              done          <= 1'b1;
              busy          <= 1'b0;
              state         <= ST_IDLE;
            end else begin
              sleep <= tail;
              step  <= '0;
              idx   <= idx_next;
              state <= ST_SCAN;
            end
          end
        end
        ST_SCAN: begin
          if (entry != '0) begin
            sleep_seconds <= sleep;
            no_refresh    <= 1'b0;
            done          <= 1'b1;
            busy          <= 1'b0;
            state         <= ST_IDLE;
          end else if (step == HOUR_W'(HOURS_PER_DAY - 1)) begin
            sleep_seconds <= '0;
            no_refresh    <= 1'b1;
            done          <= 1'b1;
            busy          <= 1'b0;
            state         <= ST_IDLE;
          end else begin
            sleep <= sleep + SLEEP_W'(SECS_PER_HOUR);
            step  <= step + 1'b1;
            idx   <= idx_next;
          end
        end
        default: begin
          busy  <= 1'b0;
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // a result only ends a query that was in flight
  a_done_after_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy))
    else $error("result without a query in flight");

  // busy is low exactly when the sequencer is idle
  a_busy_state: assert property (@(posedge clk) disable iff (rst)
    busy == (state != ST_IDLE))
    else $error("busy out of step with sequencer");

  // empty table gives zero, otherwise a positive bounded sleep
  a_result_range: assert property (@(posedge clk) disable iff (rst)
    done |-> (no_refresh ? (sleep_seconds == '0)
                         : ((sleep_seconds != '0) && (sleep_seconds <= SLEEP_W'(86400)))))
    else $error("sleep result out of range");

  // the divider is only launched while a query is being worked
  a_div_in_query: assert property (@(posedge clk) disable iff (rst)
    div_start |-> busy)
    else $error("divider started while idle");

endmodule
